// ----- hdl/swf_pkg.sv -----
// Shared types and constants for the sigma window filter.
package swf_pkg;

    localparam int QUO_W      = 8;
    localparam int ROW_W      = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd3;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_SCAN,
        ST_TAIL,
        ST_DIV
    } t_state;

endpackage

// ----- hdl/sigma_window_filter_core.sv -----
// Sigma window filter: line-store ring, window scan and a chain of divider cells.
// Sequence: an item without a result is taken in the idle state; an item with a result
// passes the centre read, the window scan (one RAM read per window pixel), the tail state
// and the chain of divider cells until the result is presented.
// Throughput: one item at a time; an item with a result blocks the input until taken.
// Reset: synchronous active low; control and configuration registers return to defaults, frame restarts.
module sigma_window_filter_core
    import swf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HALF  = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] pixel
    input  logic                  i_s_tuser,   // [0] action
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [7:0] filtered
    output logic                  o_m_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RING  = 2 * MAX_HALF + 2;
    localparam int RW    = $clog2(RING);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HALF + 1);
    localparam int NWIN  = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
    localparam int CNT_W = $clog2(NWIN + 1);
    localparam int SUM_W = $clog2(NWIN * 255 + 1);

    // configuration
    logic [10:0]      r_line_width;
    logic [ROW_W-1:0] r_frame_height;
    logic [1:0]       r_half_window;
    logic [7:0]       r_threshold;

    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [HW-1:0]    k_eff;

    always_comb begin
        if (r_line_width == 11'd0) begin
            w_eff = WW'(1);
        end else if (14'(r_line_width) > 14'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_line_width);
        end
        if (r_frame_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (14'(r_frame_height) > 14'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
        if (4'(r_half_window) > 4'(MAX_HALF)) begin
            k_eff = HW'(MAX_HALF);
        end else begin
            k_eff = HW'(r_half_window);
        end
    end

    // position state
    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic [CW-1:0]    r_in_col, r_out_col;
    logic [RW-1:0]    r_in_ring, r_out_ring;
    logic             r_last;

    // window scan
    logic [ROW_W-1:0] r_sr, r_r1;
    logic [CW-1:0]    r_sc, r_c0, r_c1;
    logic [RW-1:0]    r_sring;
    logic             r_rd_vld;
    logic             r_cap;
    logic             r_div_go;
    logic [7:0]       r_centre;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;

    // output
    logic             r_out_vld;
    logic [7:0]       r_out_data;
    logic             r_out_last;

    logic             s_acc;
    logic             frame_in;
    logic             emit;
    logic             drain_last;
    logic             in_col_end, out_col_end;
    logic             ram_we;
    logic [AW-1:0]    waddr, raddr;
    logic [7:0]       rdata;
    logic             rd_issue;
    logic             scan_col_end, scan_done;
    logic             div_in_vld;
    logic             div_out_vld;
    logic [QUO_W-1:0] div_out_quo;
    logic             finish;

    // window bounds
    logic [ROW_W-1:0] b_r0, b_r1;
    logic [CW-1:0]    b_c0, b_c1;
    logic [RW-1:0]    b_ring;
    logic [HW-1:0]    b_k;
    logic [ROW_W:0]   b_rsum;
    logic [WW:0]      b_csum;

    assign o_s_tready = (r_state == ST_IDLE) && !r_out_vld && !i_cfg_valid;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = (r_state == ST_IDLE) && !r_out_vld;
    assign frame_in   = r_in_row < h_eff;
    assign emit       = r_in_row >= (ROW_W'(k_eff) + ROW_W'(1));
    assign in_col_end  = WW'(r_in_col) == (w_eff - WW'(1));
    assign out_col_end = WW'(r_out_col) == (w_eff - WW'(1));
    assign drain_last  = (r_out_row >= h_eff - ROW_W'(1)) && out_col_end;
    assign scan_col_end = r_sc == r_c1;
    assign scan_done    = scan_col_end && (r_sr == r_r1);
    assign finish       = (r_state == ST_DIV) && div_out_vld;
    assign div_in_vld   = r_div_go;

    always_comb begin
        b_r0 = (r_out_row > ROW_W'(k_eff)) ? r_out_row - ROW_W'(k_eff) : '0;
        b_rsum = (ROW_W + 1)'(r_out_row) + (ROW_W + 1)'(k_eff);
        b_r1 = (b_rsum > (ROW_W + 1)'(h_eff - ROW_W'(1))) ? h_eff - ROW_W'(1)
                                                          : b_rsum[ROW_W-1:0];
        b_c0 = (r_out_col > CW'(k_eff)) ? r_out_col - CW'(k_eff) : '0;
        b_csum = (WW + 1)'(r_out_col) + (WW + 1)'(k_eff);
        b_c1 = (b_csum > (WW + 1)'(w_eff - WW'(1))) ? CW'(w_eff - WW'(1))
                                                    : CW'(b_csum);
        b_k = HW'(r_out_row - b_r0);
        b_ring = (r_out_ring >= RW'(b_k)) ? r_out_ring - RW'(b_k)
                                          : RW'(RING) + r_out_ring - RW'(b_k);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (!frame_in) begin
                        n_state = ST_CENTRE;
                    end else if (i_s_tuser == ACT_PIXEL && emit) begin
                        n_state = ST_CENTRE;
                    end
                end
            end
            ST_CENTRE: n_state = ST_SCAN;
            ST_SCAN:   n_state = scan_done ? ST_TAIL : ST_SCAN;
            ST_TAIL:   n_state = ST_DIV;
            ST_DIV:    n_state = div_out_vld ? ST_IDLE : ST_DIV;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        ram_we     = 1'b0;
        rd_issue   = 1'b0;
        raddr      = AW'(r_sring) * AW'(MAX_WIDTH) + AW'(r_sc);
        case (r_state)
            ST_IDLE: begin
                ram_we = s_acc && frame_in && (i_s_tuser == ACT_PIXEL);
            end
            ST_CENTRE: begin
                raddr = AW'(r_out_ring) * AW'(MAX_WIDTH) + AW'(r_out_col);
            end
            ST_SCAN: rd_issue = 1'b1;
            default: ;
        endcase
    end

    assign waddr = AW'(r_in_ring) * AW'(MAX_WIDTH) + AW'(r_in_col);

    swf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (i_s_tdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_line_width   <= 11'd1024;
            r_frame_height <= 13'd1024;
            r_half_window  <= 2'd1;
            r_threshold    <= 8'd20;
            r_in_row       <= '0;
            r_in_col       <= '0;
            r_in_ring      <= '0;
            r_out_row      <= '0;
            r_out_col      <= '0;
            r_out_ring     <= '0;
            r_rd_vld       <= 1'b0;
            r_cap          <= 1'b0;
            r_div_go       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_issue;
            r_cap    <= r_state == ST_CENTRE;
            r_div_go <= r_state == ST_TAIL;
            if (o_m_tvalid && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (finish) begin
                r_out_vld <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LINE_WIDTH:   r_line_width   <= i_cfg_data[10:0];
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    REG_HALF_WINDOW:  r_half_window  <= i_cfg_data[1:0];
                    REG_THRESHOLD:    r_threshold    <= i_cfg_data[7:0];
                    default: ;
                endcase
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_in_ring  <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_ring <= '0;
            end else begin
                if (ram_we) begin
                    if (in_col_end) begin
                        r_in_col  <= '0;
                        r_in_row  <= r_in_row + ROW_W'(1);
                        r_in_ring <= (r_in_ring == RW'(RING - 1)) ? '0
                                                                  : r_in_ring + RW'(1);
                    end else begin
                        r_in_col <= r_in_col + CW'(1);
                    end
                end
                if (finish) begin
                    if (r_last) begin
                        r_in_row   <= '0;
                        r_in_col   <= '0;
                        r_in_ring  <= '0;
                        r_out_row  <= '0;
                        r_out_col  <= '0;
                        r_out_ring <= '0;
                    end else if (out_col_end) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + ROW_W'(1);
                        r_out_ring <= (r_out_ring == RW'(RING - 1)) ? '0
                                                                    : r_out_ring + RW'(1);
                    end else begin
                        r_out_col <= r_out_col + CW'(1);
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_last <= !frame_in && drain_last;
        end
        if (r_state == ST_CENTRE) begin
            r_sr    <= b_r0;
            r_r1    <= b_r1;
            r_sc    <= b_c0;
            r_c0    <= b_c0;
            r_c1    <= b_c1;
            r_sring <= b_ring;
            r_sum   <= '0;
            r_cnt   <= '0;
        end
        if (rd_issue) begin
            if (scan_col_end) begin
                r_sc    <= r_c0;
                r_sr    <= r_sr + ROW_W'(1);
                r_sring <= (r_sring == RW'(RING - 1)) ? '0 : r_sring + RW'(1);
            end else begin
                r_sc <= r_sc + CW'(1);
            end
        end
        if (r_cap) begin
            r_centre <= rdata;
        end
        if (r_rd_vld) begin
            if (((rdata > r_centre) ? rdata - r_centre : r_centre - rdata)
                    <= r_threshold) begin
                r_sum <= r_sum + SUM_W'(rdata);
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
        if (finish) begin
            r_out_data <= div_out_quo;
            r_out_last <= r_last;
        end
    end

    // divider chain
    logic             c_vld [QUO_W+1];
    logic [SUM_W-1:0] c_rem [QUO_W+1];
    logic [CNT_W-1:0] c_den [QUO_W+1];
    logic [QUO_W-1:0] c_quo [QUO_W+1];

    assign c_vld[0] = div_in_vld;
    assign c_rem[0] = r_sum;
    assign c_den[0] = r_cnt;
    assign c_quo[0] = '0;

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        swf_div_cell #(
            .SUM_W (SUM_W),
            .CNT_W (CNT_W),
            .BIT   (QUO_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (c_vld[g]),
            .i_rem   (c_rem[g]),
            .i_den   (c_den[g]),
            .i_quo   (c_quo[g]),
            .o_vld   (c_vld[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_den   (c_den[g+1]),
            .o_quo   (c_quo[g+1])
        );
    end

    assign div_out_vld = c_vld[QUO_W];
    assign div_out_quo = c_quo[QUO_W];

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- hdl/swf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module swf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/swf_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit and passes on.
module swf_div_cell
    import swf_pkg::*;
#(
    parameter int SUM_W = 16,
    parameter int CNT_W = 8,
    parameter int BIT   = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [SUM_W-1:0]  i_rem,
    input  logic [CNT_W-1:0]  i_den,
    input  logic [QUO_W-1:0]  i_quo,
    output logic              o_vld,
    output logic [SUM_W-1:0]  o_rem,
    output logic [CNT_W-1:0]  o_den,
    output logic [QUO_W-1:0]  o_quo
);

    localparam int DW = SUM_W + QUO_W;

    logic             r_vld;
    logic [SUM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic [DW-1:0]    den_sh;
    logic [DW-1:0]    rem_x;
    logic [DW-1:0]    diff;
    logic             take;

    always_comb begin
        den_sh = DW'(i_den) << BIT;
        rem_x  = DW'(i_rem);
        diff   = rem_x - den_sh;
        take   = rem_x >= den_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_den <= i_den;
        r_rem <= take ? diff[SUM_W-1:0] : i_rem;
        r_quo <= i_quo | (take ? (QUO_W'(1) << BIT) : QUO_W'(0));
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

// ----- tb/sigma_window_filter_core_chk.sv -----
// Checker for the sigma window filter: watches all channels, predicts results and compares.
module sigma_window_filter_core_chk
    import swf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [7:0]            i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [7:0]            i_m_tdata,
    input  logic                  i_m_tlast,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int LINE_MAX  = 1024;
    localparam int HALF_MAX  = 3;
    localparam int RING_ROWS = 2 * HALF_MAX + 2;

    typedef struct packed {
        logic [7:0] filtered;
        logic       last_of_frame;
    } t_pixel_out;

    t_pixel_out       expected_pixels[$];
    logic [7:0]       line_ring [0:RING_ROWS*LINE_MAX-1];
    logic [10:0]      cfg_width;
    logic [12:0]      cfg_height;
    logic [1:0]       cfg_half;
    logic [7:0]       cfg_thresh;
    int unsigned      in_row, in_col, out_row, out_col;

    assign o_pending = expected_pixels.size();

    function automatic int unsigned ring_addr(int unsigned row, int unsigned col);
        return (row % RING_ROWS) * LINE_MAX + (col % LINE_MAX);
    endfunction

    function automatic int unsigned width_eff();
        if (cfg_width == 0) return 1;
        return (cfg_width > LINE_MAX) ? LINE_MAX : cfg_width;
    endfunction

    function automatic int unsigned height_eff();
        if (cfg_height == 0) return 1;
        return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
    endfunction

    function automatic logic [7:0] sigma_mean(int unsigned w, int unsigned hgt, int unsigned h);
        int unsigned r0, r1, c0, c1, centre, sum, cnt, p, d;
        r0 = (out_row > h) ? out_row - h : 0;
        r1 = (out_row + h > hgt - 1) ? hgt - 1 : out_row + h;
        c0 = (out_col > h) ? out_col - h : 0;
        c1 = (out_col + h > w - 1) ? w - 1 : out_col + h;
        centre = line_ring[ring_addr(out_row, out_col)];
        sum = 0;
        cnt = 0;
        for (int unsigned r = r0; r <= r1; r++) begin
            for (int unsigned c = c0; c <= c1; c++) begin
                p = line_ring[ring_addr(r, c)];
                d = (p > centre) ? p - centre : centre - p;
                if (d <= cfg_thresh) begin
                    sum += p;
                    cnt++;
                end
            end
        end
        if (cnt == 0) return centre[7:0];
        return 8'((sum / cnt) & 255);
    endfunction

    task automatic step_out(int unsigned w);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
    endtask

    task automatic predict_item(logic act, logic [7:0] pix);
        int unsigned w, hgt, h;
        t_pixel_out  res;
        w = width_eff();
        hgt = height_eff();
        h = cfg_half;
        if (in_row < hgt) begin
            if (act == ACT_DRAIN) return;
            line_ring[ring_addr(in_row, in_col)] = pix;
            if (in_row >= h + 1) begin
                res.filtered = sigma_mean(w, hgt, h);
                res.last_of_frame = 1'b0;
                expected_pixels.push_back(res);
                step_out(w);
            end
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end else begin
            res.filtered = sigma_mean(w, hgt, h);
            res.last_of_frame = (out_row >= hgt - 1) && (out_col >= w - 1);
            expected_pixels.push_back(res);
            step_out(w);
            if (res.last_of_frame) begin
                in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            end
        end
    endtask

    task automatic report_mismatch(string what, int exp_v, int act_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch %s: expected %0d actual %0d", what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        t_pixel_out exp_px;
        if (!i_rst_n) begin
            cfg_width  = 11'd1024;
            cfg_height = 13'd1024;
            cfg_half   = 2'd1;
            cfg_thresh = 8'd20;
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            o_fail_count = 0;
            expected_pixels.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected transaction", -1, i_m_tdata);
                end else begin
                    exp_px = expected_pixels.pop_front();
                    if (i_m_tdata !== exp_px.filtered)
                        report_mismatch("filtered", exp_px.filtered, i_m_tdata);
                    if (i_m_tlast !== exp_px.last_of_frame)
                        report_mismatch("tlast", exp_px.last_of_frame, i_m_tlast);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LINE_WIDTH:   cfg_width  = i_cfg_data[10:0];
                    REG_FRAME_HEIGHT: cfg_height = i_cfg_data[12:0];
                    REG_HALF_WINDOW:  cfg_half   = i_cfg_data[1:0];
                    REG_THRESHOLD:    cfg_thresh = i_cfg_data[7:0];
                    default: ;
                endcase
                in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            end
            if (i_s_tvalid && i_s_tready)
                predict_item(i_s_tuser, i_s_tdata);
        end
    end

endmodule

// ----- tb/sigma_window_filter_core_tb.sv -----
// Testbench top for the sigma window filter: clock, reset, stimulus and verdict.
module sigma_window_filter_core_tb;
    import swf_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [7:0]            o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles;
    int                    counted_items;
    bit                    rx_hold_req;
    bit                    rx_hold_done;
    bit                    tx_no_gaps;

    sigma_window_filter_core dut (.*);

    sigma_window_filter_core_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL sigma_window_filter_core");
            $finish;
        end
    end

    // output side backpressure
    initial begin
        i_m_tready = 1'b0;
        rx_hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !rx_hold_done) begin
                i_m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                rx_hold_done = 1'b1;
            end else if ($urandom_range(0, 199) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge i_clk);
            end else if ($urandom_range(0, 299) == 0) begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(20, 150)) @(posedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(0, 99) < 75);
            end
        end
    end

    task automatic send_item(logic act, logic [7:0] pix);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_tready);
        gap = 0;
        if (!tx_no_gaps) begin
            if ($urandom_range(0, 99) < 4) gap = $urandom_range(10, 40);
            else if ($urandom_range(0, 99) < 25) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_filter(int w, int hgt, int h, int thr);
        write_reg(REG_LINE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(hgt));
        write_reg(REG_HALF_WINDOW, CFG_DATA_W'(h));
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    endtask

    // one frame of clustered pixels followed by its flush
    task automatic run_frame(int w, int hgt, int h);
        int base, pix, flushes;
        base = $urandom_range(0, 255);
        for (int i = 0; i < w * hgt; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(ACT_DRAIN, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0) begin
                pix = $urandom_range(0, 255);
            end else begin
                pix = base + $urandom_range(0, 40) - 20;
                if (pix < 0) pix = 0;
                if (pix > 255) pix = 255;
            end
            send_item(ACT_PIXEL, 8'(pix));
            counted_items++;
        end
        flushes = w * hgt - ((hgt > h + 1) ? (hgt - h - 1) * w : 0);
        for (int i = 0; i < flushes; i++) begin
            send_item(($urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_DRAIN,
                      8'($urandom_range(0, 255)));
            counted_items++;
        end
    endtask

    initial begin
        int w, hgt, h, thr;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = ACT_PIXEL;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_LINE_WIDTH;
        i_cfg_data = '0;
        rx_hold_req = 1'b0;
        tx_no_gaps = 1'b0;
        counted_items = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 4x3 frame, extreme pixels, ignored drain, pixel after input
        set_filter(4, 3, 1, 20);
        send_item(ACT_DRAIN, 8'hFF);
        send_item(ACT_PIXEL, 8'd0);   send_item(ACT_PIXEL, 8'd255);
        send_item(ACT_PIXEL, 8'd10);  send_item(ACT_PIXEL, 8'd20);
        send_item(ACT_PIXEL, 8'd30);  send_item(ACT_PIXEL, 8'd255);
        send_item(ACT_PIXEL, 8'd0);   send_item(ACT_PIXEL, 8'd25);
        send_item(ACT_PIXEL, 8'd15);  send_item(ACT_PIXEL, 8'd5);
        send_item(ACT_PIXEL, 8'd240); send_item(ACT_PIXEL, 8'd128);
        for (int i = 0; i < 8; i++)
            send_item((i % 2) ? ACT_PIXEL : ACT_DRAIN, 8'hAA);
        wait_drained();

        // zero width and height act as one; zero radius and threshold
        set_filter(0, 0, 0, 0);
        run_frame(1, 1, 0);
        wait_drained();

        // top height and width values, then a frame shorter than the window
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        write_reg(REG_LINE_WIDTH, 13'h7FF);
        set_filter(3, 2, 3, 255);
        run_frame(3, 2, 3);
        wait_drained();

        // wide two-row frame, all outputs from the flush
        set_filter(100, 2, 3, 255);
        run_frame(100, 2, 3);
        wait_drained();

        rx_hold_req = 1'b1;
        while (counted_items < 1050) begin
            w = $urandom_range(1, 12);
            hgt = $urandom_range(1, 10);
            h = $urandom_range(0, 3);
            thr = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 255 : 0)
                                               : $urandom_range(5, 50);
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            set_filter(w, hgt, h, thr);
            repeat ($urandom_range(1, 2)) run_frame(w, hgt, h);
            wait_drained();
        end

        if (fail_count == 0)
            $display("PASS sigma_window_filter_core");
        else
            $display("FAIL sigma_window_filter_core");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/swf_pkg.sv
hdl/swf_ram.sv
hdl/swf_div_cell.sv
hdl/sigma_window_filter_core.sv
tb/sigma_window_filter_core_chk.sv
tb/sigma_window_filter_core_tb.sv
